>>> sv/integer_to_base_digits_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to base digits unit
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_BASE_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_BASE_DIGITS_UNIT_ASSERT_SVH

// same-cycle implication
`define ITOB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itob assertion failed");

// next-cycle implication
`define ITOB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itob assertion failed");

`endif

>>> sv/itob_pkg.sv
// ----------------------------------------------------------------------------
// itob_pkg
// Shared widths, constants, microcode format and control store of the
// integer to base digits unit.
// ----------------------------------------------------------------------------
package itob_pkg;

   // field widths
   localparam int WORD_BITS  = 32;
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;
   localparam int DIGIT_BITS = 6;
   localparam int STACK_DEPTH = WORD_BITS;
   localparam int IDX_BITS   = $clog2(STACK_DEPTH);
   localparam int CNT_BITS   = $clog2(STACK_DEPTH + 1);
   localparam int BIT_BITS   = $clog2(WORD_BITS);
   localparam int STEP_BITS  = 4;

   // radix limits
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_BITS-1:0] DEC_DIGITS  = 6'd10;

   // character codes
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_A     = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 7'h00;

   // step addresses of the program
   localparam logic [STEP_BITS-1:0] STEP_FETCH   = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_CHKRAD  = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_ERR     = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_DIVINIT = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_DIVSTEP = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_PUSH    = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_SIGN    = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_RDWAIT  = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_EMIT    = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_RETURN  = 4'd9;

   // datapath action of one step
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_DIVINIT,
      ACT_DIVSTEP,
      ACT_PUSH,
      ACT_EMIT_SIGN,
      ACT_EMIT_DIGIT,
      ACT_EMIT_ERR
   } act_type;

   // jump condition of one step
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ACCEPT,
      COND_RADIX_OK,
      COND_DIV_BUSY,
      COND_MAG_NZ,
      COND_MORE_DIGITS
   } cond_type;

   typedef struct packed {
      act_type                act;
      cond_type               cond;
      logic [STEP_BITS-1:0]   target;
   } ctl_word_type;

   // control store
   function automatic ctl_word_type ucode_rom(input logic [STEP_BITS-1:0] addr);
      ctl_word_type w;
      unique case (addr)
         STEP_FETCH:   w = '{ACT_LOAD,       COND_NO_ACCEPT,   STEP_FETCH};
         STEP_CHKRAD:  w = '{ACT_NONE,       COND_RADIX_OK,    STEP_DIVINIT};
         STEP_ERR:     w = '{ACT_EMIT_ERR,   COND_ALWAYS,      STEP_FETCH};
         STEP_DIVINIT: w = '{ACT_DIVINIT,    COND_NEVER,       STEP_FETCH};
         STEP_DIVSTEP: w = '{ACT_DIVSTEP,    COND_DIV_BUSY,    STEP_DIVSTEP};
         STEP_PUSH:    w = '{ACT_PUSH,       COND_MAG_NZ,      STEP_DIVINIT};
         STEP_SIGN:    w = '{ACT_EMIT_SIGN,  COND_NEVER,       STEP_FETCH};
         STEP_RDWAIT:  w = '{ACT_NONE,       COND_NEVER,       STEP_FETCH};
         STEP_EMIT:    w = '{ACT_EMIT_DIGIT, COND_MORE_DIGITS, STEP_RDWAIT};
         STEP_RETURN:  w = '{ACT_NONE,       COND_ALWAYS,      STEP_FETCH};
         default:      w = '{ACT_NONE,       COND_ALWAYS,      STEP_FETCH};
      endcase
      return w;
   endfunction

   // digit value to ASCII
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < DEC_DIGITS) begin
         c = CHAR_ZERO + {1'b0, d};
      end else begin
         c = CHAR_A + {1'b0, d} - {1'b0, DEC_DIGITS};
      end
      return c;
   endfunction

endpackage

>>> sv/itob_req_if.sv
// ----------------------------------------------------------------------------
// itob_req_if
// Input channel: one signed word per item.
// ----------------------------------------------------------------------------
interface itob_req_if;
   import itob_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> sv/itob_rsp_if.sv
// ----------------------------------------------------------------------------
// itob_rsp_if
// Result channel: one character per item.
// ----------------------------------------------------------------------------
interface itob_rsp_if;
   import itob_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 last;
   logic                 bad_radix;

   modport source (output valid, output char_code, output last, output bad_radix,
                   input ready);
   modport sink   (input valid, input char_code, input last, input bad_radix,
                   output ready);
endinterface

>>> sv/integer_to_base_digits_unit.sv
// Steps per item: fetch, radix check, then for each digit a divider init, 32 restoring
// bit-serial division steps and a push; then the sign ('-' when negative), and each digit
// from the top of the stack through a read-wait and an emit step. A bad radix gives one
// error item instead. One item at a time: no new value is taken until fetch is reached.
// An emitting step stalls while the output register holds a character not yet taken.
// Reset (synchronous, active high) returns the sequencer to fetch and sets radix to 10.
// ----------------------------------------------------------------------------
// integer_to_base_digits_unit
// Converts a signed word to ASCII text in a configured base. A small control
// store sequences a restoring divider, a digit stack and the output register.
// ----------------------------------------------------------------------------
`include "integer_to_base_digits_unit_assert.svh"

module integer_to_base_digits_unit (
   input  logic                           clock,
   input  logic                           reset,
   itob_req_if.sink                       req_if,
   itob_rsp_if.source                     rsp_if,
   input  logic                           csr_write_en,
   input  logic [itob_pkg::RADIX_BITS-1:0] csr_write_data
);
   import itob_pkg::*;

   // sequencer
   logic [STEP_BITS-1:0]  pc_ff, pc_in;
   ctl_word_type          ctl;

   // datapath
   logic [RADIX_BITS-1:0] radix_ff;
   logic [WORD_BITS-1:0]  mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [BIT_BITS-1:0]   bit_ff, bit_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIGIT_BITS-1:0] digit_stack_ff [STACK_DEPTH];
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic [IDX_BITS-1:0]   rd_addr;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic                  req_accept;
   logic                  radix_ok;
   logic                  is_emit, stall, jump;
   logic [DIGIT_BITS:0]   trial;
   logic                  trial_ge;
   logic [WORD_BITS-1:0]  value_raw;

   assign ctl        = ucode_rom(pc_ff);
   assign req_if.ready = (pc_ff == STEP_FETCH);
   assign req_accept = req_if.valid && req_if.ready;
   assign radix_ok   = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign value_raw  = req_if.value;

   // an emitting step waits for a free output register
   assign is_emit = (ctl.act == ACT_EMIT_SIGN) || (ctl.act == ACT_EMIT_DIGIT) ||
                    (ctl.act == ACT_EMIT_ERR);
   assign stall   = is_emit && rsp_valid_ff && !rsp_if.ready;

   // one restoring division step
   assign trial    = {rem_ff, mag_ff[WORD_BITS-1]};
   assign trial_ge = (trial >= {1'b0, radix_ff});

   // jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:       jump = 1'b0;
         COND_ALWAYS:      jump = 1'b1;
         COND_NO_ACCEPT:   jump = !req_accept;
         COND_RADIX_OK:    jump = radix_ok;
         COND_DIV_BUSY:    jump = (bit_ff != {BIT_BITS{1'b1}});
         COND_MAG_NZ:      jump = (mag_ff != '0);
         COND_MORE_DIGITS: jump = (cnt_ff != CNT_BITS'(1));
         default:          jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      priority if (stall) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + STEP_BITS'(1);
      end
   end

   // datapath actions
   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      unique case (ctl.act)
         ACT_NONE: begin
         end
         ACT_LOAD: begin
            if (req_accept) begin
               neg_in = value_raw[WORD_BITS-1];
               mag_in = value_raw[WORD_BITS-1] ? (~value_raw + WORD_BITS'(1)) : value_raw;
               cnt_in = '0;
            end
         end
         ACT_DIVINIT: begin
            rem_in = '0;
            bit_in = '0;
         end
         ACT_DIVSTEP: begin
            rem_in = trial_ge ? DIGIT_BITS'(trial - {1'b0, radix_ff}) : trial[DIGIT_BITS-1:0];
            mag_in = {mag_ff[WORD_BITS-2:0], trial_ge};
            bit_in = bit_ff + BIT_BITS'(1);
         end
         ACT_PUSH: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
         ACT_EMIT_SIGN: begin
            if (!stall && neg_ff) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b0;
            end
         end
         ACT_EMIT_DIGIT: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(rd_data_ff);
               rsp_last_in  = (cnt_ff == CNT_BITS'(1));
               rsp_bad_in   = 1'b0;
               cnt_in       = cnt_ff - CNT_BITS'(1);
            end
         end
         ACT_EMIT_ERR: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_NONE;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_FETCH;
         radix_ff     <= RADIX_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            radix_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // digit stack: pushed least significant first, read back from the top
   assign rd_addr = IDX_BITS'(cnt_ff - CNT_BITS'(1));

   always_ff @(posedge clock) begin
      if (ctl.act == ACT_PUSH) begin
         digit_stack_ff[cnt_ff[IDX_BITS-1:0]] <= rem_ff;
      end
      rd_data_ff <= digit_stack_ff[rd_addr];
   end

   // result channel
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = rsp_char_ff;
   assign rsp_if.last      = rsp_last_ff;
   assign rsp_if.bad_radix = rsp_bad_ff;

   // checks
   `ITOB_ASSERT_IMPL(a_err_sole, rsp_valid_ff && rsp_bad_ff, rsp_last_ff && (rsp_char_ff == CHAR_NONE))
   `ITOB_ASSERT_IMPL(a_accept_empty, req_accept, cnt_ff == '0)
   `ITOB_ASSERT_IMPL(a_rem_below_radix, pc_ff == STEP_DIVSTEP, rem_ff < radix_ff)
   `ITOB_ASSERT_IMPL(a_stack_room, ctl.act == ACT_PUSH, cnt_ff < CNT_BITS'(STACK_DEPTH))
   `ITOB_ASSERT_NEXT(a_accept_to_check, req_accept, pc_ff == STEP_CHKRAD)

endmodule

>>> verif/itob_text_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itob_text_check
// Watches the request, result and register ports of the integer to base
// digits unit. Every accepted value is turned into the characters it should
// produce under the current base, and every result item is compared with the
// oldest of those characters.
// ----------------------------------------------------------------------------
module itob_text_check (
   input  logic                           clock,
   input  logic                           reset,
   itob_req_if                            req_mon,
   itob_rsp_if                            rsp_mon,
   input  logic                           csr_write_en,
   input  logic [itob_pkg::RADIX_BITS-1:0] csr_write_data,
   output int                             mismatch_count,
   output int                             chars_pending
);
   import itob_pkg::*;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last;
      logic                 bad_radix;
   } text_char_type;

   // characters still owed by the block, oldest first
   text_char_type         owed_chars[$];
   logic [RADIX_BITS-1:0] base_shadow;

   // text of one word in the given base, appended to the owed characters
   function automatic void predict_text(input logic [WORD_BITS-1:0] word,
                                        input logic [RADIX_BITS-1:0] base);
      logic [WORD_BITS-1:0]  mag;
      logic [WORD_BITS-1:0]  wide_base;
      logic [DIGIT_BITS-1:0] digits[$];
      logic [DIGIT_BITS-1:0] d;
      text_char_type         ch;
      if (base < RADIX_MIN || base > RADIX_MAX) begin
         ch = '{CHAR_NONE, 1'b1, 1'b1};
         owed_chars.push_back(ch);
         return;
      end
      wide_base = WORD_BITS'(base);
      // two's complement magnitude; the most negative word maps onto itself
      mag = word[WORD_BITS-1] ? (~word + 1'b1) : word;
      do begin
         digits.push_front(DIGIT_BITS'(mag % wide_base));
         mag = mag / wide_base;
      end while (mag != '0);
      if (word[WORD_BITS-1]) begin
         ch = '{CHAR_MINUS, 1'b0, 1'b0};
         owed_chars.push_back(ch);
      end
      for (int i = 0; i < digits.size(); i++) begin
         d = digits[i];
         if (d < DEC_DIGITS) begin
            ch.char_code = CHAR_ZERO + CHAR_BITS'(d);
         end else begin
            ch.char_code = CHAR_A + CHAR_BITS'(d - DEC_DIGITS);
         end
         ch.last      = (i == digits.size() - 1);
         ch.bad_radix = 1'b0;
         owed_chars.push_back(ch);
      end
   endfunction

   // predict on accepted values, compare accepted result items
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         base_shadow    = RADIX_RESET;
         mismatch_count = 0;
         owed_chars.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_text(req_mon.value, base_shadow);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_chars.size() == 0) begin
               $display("%0t: unexpected item, char_code %h last %b bad_radix %b",
                        $time, rsp_mon.char_code, rsp_mon.last, rsp_mon.bad_radix);
               mismatch_count++;
            end else begin
               want = owed_chars.pop_front();
               if (rsp_mon.char_code !== want.char_code) begin
                  $display("%0t: char_code expected %h actual %h",
                           $time, want.char_code, rsp_mon.char_code);
                  mismatch_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $display("%0t: last expected %b actual %b",
                           $time, want.last, rsp_mon.last);
                  mismatch_count++;
               end
               if (rsp_mon.bad_radix !== want.bad_radix) begin
                  $display("%0t: bad_radix expected %b actual %b",
                           $time, want.bad_radix, rsp_mon.bad_radix);
                  mismatch_count++;
               end
            end
         end
         // register write lands at this edge, after any accept above
         if (csr_write_en) begin
            base_shadow = csr_write_data;
         end
      end
      chars_pending = owed_chars.size();
   end

endmodule

>>> verif/integer_to_base_digits_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_base_digits_unit_tb
// Drives the integer to base digits unit with edge values and random words
// under a range of valid and invalid bases, with random gaps on the request
// side and random stalls on the result side; the text checker scores results.
// ----------------------------------------------------------------------------
module integer_to_base_digits_unit_tb;
   import itob_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 1300;
   localparam int SETTINGS_PER_PHASE = 4;
   localparam int ITEMS_PER_SETTING  = 6;

   typedef struct {
      logic [RADIX_BITS-1:0]       base;
      logic signed [WORD_BITS-1:0] value;
   } probe_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [RADIX_BITS-1:0] csr_write_data;
   int                    mismatch_count;
   int                    chars_pending;
   int                    cycle_count;
   int                    send_gap_pct;
   int                    recv_stall_pct;

   itob_req_if req_if ();
   itob_rsp_if rsp_if ();

   integer_to_base_digits_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   itob_text_check u_text_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   // edge cases: reset base, binary, base 36 and the invalid bases
   probe_type probes[22] = '{
      '{6'd10, 32'sd0},           '{6'd10, 32'sd1},
      '{6'd10, -32'sd1},          '{6'd10, 32'sd9},
      '{6'd10, 32'sd10},          '{6'd10, -32'sd10},
      '{6'd10, 32'sh7FFF_FFFF},   '{6'd10, 32'sh8000_0000},
      '{6'd10, 32'sd1000000000},
      '{6'd2,  32'sh8000_0000},   '{6'd2,  32'sh7FFF_FFFF},
      '{6'd2,  32'sd0},           '{6'd2,  -32'sd1},
      '{6'd36, 32'sd35},          '{6'd36, 32'sd36},
      '{6'd36, -32'sd1295},       '{6'd36, 32'sh7FFF_FFFF},
      '{6'd36, 32'sh8000_0000},
      '{6'd0,  32'sd5},           '{6'd1,  -32'sd7},
      '{6'd37, 32'sd0},           '{6'd63, 32'sh8000_0000}
   };

   // bases for the random part; later settings draw a valid base at random
   logic [RADIX_BITS-1:0] base_plan[12] = '{
      6'd2, 6'd36, 6'd0, 6'd10, 6'd63, 6'd16, 6'd1, 6'd37, 6'd3, 6'd35, 6'd8, 6'd2
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("integer_to_base_digits_unit_tb: errors");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // one value onto the request channel; returns at the falling edge after
   // the accept with valid still high
   task automatic send_value(input logic signed [WORD_BITS-1:0] v);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // let the block finish every owed character
   task automatic drain();
      req_if.valid <= 1'b0;
      while (chars_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_base(input logic [RADIX_BITS-1:0] base);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= base;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // mix of full-range words, small values, edges and near powers of the base
   function automatic logic signed [WORD_BITS-1:0] pick_value(input logic [RADIX_BITS-1:0] base);
      int                   kind;
      int                   steps;
      logic [63:0]          power;
      logic [WORD_BITS-1:0] v;
      kind = $urandom_range(99);
      if (kind < 40) begin
         v = $urandom;
      end else if (kind < 70) begin
         v = WORD_BITS'($urandom_range(2000)) - 32'd1000;
      end else if (kind < 85) begin
         case ($urandom_range(4))
            0: v = 32'h0000_0000;
            1: v = 32'h0000_0001;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h7FFF_FFFF;
            default: v = 32'h8000_0000;
         endcase
      end else begin
         power = 64'd1;
         steps = $urandom_range(32);
         repeat (steps) begin
            if (base >= RADIX_MIN && power * base <= 64'hFFFF_FFFF) begin
               power = power * base;
            end
         end
         v = power[WORD_BITS-1:0] - WORD_BITS'($urandom_range(1));
         if ($urandom_range(1) == 1) begin
            v = -v;
         end
      end
      return v;
   endfunction

   // stimulus and verdict
   initial begin
      logic [RADIX_BITS-1:0] base;
      logic [RADIX_BITS-1:0] current_base;
      int                    k;
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_if.valid   = 1'b0;
      req_if.value   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, starting on the reset base
      current_base = RADIX_RESET;
      foreach (probes[i]) begin
         if (probes[i].base != current_base) begin
            write_base(probes[i].base);
            current_base = probes[i].base;
         end
         send_value(probes[i].value);
      end

      // random part over the request gap and result stall phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 64; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 64; end
            default: begin send_gap_pct = 15; recv_stall_pct = 15; end
         endcase
         for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            k = phase * SETTINGS_PER_PHASE + s;
            if (k < 12) begin
               base = base_plan[k];
            end else begin
               base = RADIX_BITS'($urandom_range(RADIX_MAX, RADIX_MIN));
            end
            write_base(base);
            repeat (ITEMS_PER_SETTING) send_value(pick_value(base));
         end
      end

      // catch late or extra characters
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("integer_to_base_digits_unit_tb: clean");
      end else begin
         $display("integer_to_base_digits_unit_tb: errors");
      end
      $finish;
   end

endmodule

>>> integer_to_base_digits_unit.f
+incdir+sv
sv/itob_pkg.sv
sv/itob_req_if.sv
sv/itob_rsp_if.sv
sv/integer_to_base_digits_unit.sv
verif/itob_text_check.sv
verif/integer_to_base_digits_unit_tb.sv
